@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define NMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define NMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/nms_pkg.sv @@
// Shared types and constants of the neighbor peak mass shift block.
package nms_pkg;

  // Sample and sum widths.
  localparam int MASS_W = 16;
  localparam int SUM_W  = MASS_W + 2;

  // Result queue geometry; one request yields at most MAX_PUSH results.
  localparam int MAX_PUSH = 3;
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = 2;
  localparam int Q_CW     = 3;
  localparam int PUSH_CW  = 2;

  // Frame position codes.
  localparam logic [1:0] POS_START = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_MANY  = 2'd2;

  // One output bin.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
  } res_t;

  // Results produced by one accepted request.
  typedef struct packed {
    logic [PUSH_CW-1:0]      cnt;
    res_t [MAX_PUSH-1:0]     res;
  } push_t;

endpackage

@@ rtl/nms_core.sv @@
// Three-sample window and mass redistribution for one request per cycle.
module nms_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [nms_pkg::MASS_W-1:0] mass_i,
  input  logic                      frame_end_i,
  output nms_pkg::push_t            push_o
);

  logic [nms_pkg::MASS_W-1:0] older_q, older_d;
  logic [nms_pkg::MASS_W-1:0] newer_q, newer_d;
  logic [nms_pkg::SUM_W-1:0]  early_q, early_d;
  logic [nms_pkg::SUM_W-1:0]  late_q, late_d;
  logic [1:0]                 pos_q, pos_d;

  logic [nms_pkg::SUM_W-1:0]  x_ext, c_ext, early, late, fresh;
  logic                       lg, rg, to_early;
  logic [nms_pkg::PUSH_CW-1:0] n;

  assign x_ext = {2'b00, mass_i};
  assign c_ext = {2'b00, newer_q};
  assign lg    = older_q > newer_q;
  assign rg    = mass_i > newer_q;
  // Left wins when only it is larger, or when it is strictly the larger one.
  assign to_early = lg && (!rg || (older_q > mass_i));

  // Decide the destination of the middle sample and build the results.
  always_comb begin
    older_d = older_q;
    newer_d = newer_q;
    early_d = early_q;
    late_d  = late_q;
    pos_d   = pos_q;
    early   = early_q;
    late    = late_q;
    fresh   = '0;
    n       = '0;
    push_o  = '0;
    if (accept_i) begin
      unique case (pos_q)
        nms_pkg::POS_START: begin
          older_d = '0;
          early_d = '0;
          late_d  = '0;
          if (frame_end_i) begin
            // single-sample frame keeps its mass
            push_o.res[0] = '{sum: x_ext, last: 1'b1};
            n       = nms_pkg::PUSH_CW'(1);
            newer_d = '0;
            pos_d   = nms_pkg::POS_START;
          end else begin
            newer_d = mass_i;
            pos_d   = nms_pkg::POS_ONE;
          end
        end
        default: begin
          if (pos_q == nms_pkg::POS_ONE) begin
            // left edge sample: only a right neighbor
            if (rg) fresh = c_ext;
            else    late  = late_q + c_ext;
          end else begin
            if (to_early)     early = early_q + c_ext;
            else if (rg)      fresh = c_ext;
            else              late  = late_q + c_ext;
            push_o.res[0] = '{sum: early, last: 1'b0};
            n = nms_pkg::PUSH_CW'(1);
          end
          // advance the window
          early = late;
          late  = fresh;
          if (frame_end_i) begin
            // right edge sample: only a left neighbor, then flush
            if (newer_q > mass_i) early = early + x_ext;
            else                  late  = late + x_ext;
            push_o.res[n] = '{sum: early, last: 1'b0};
            push_o.res[nms_pkg::PUSH_CW'(n + 2'd1)] = '{sum: late, last: 1'b1};
            n       = nms_pkg::PUSH_CW'(n + 2'd2);
            older_d = '0;
            newer_d = '0;
            early_d = '0;
            late_d  = '0;
            pos_d   = nms_pkg::POS_START;
          end else begin
            older_d = newer_q;
            newer_d = mass_i;
            early_d = early;
            late_d  = late;
            pos_d   = nms_pkg::POS_MANY;
          end
        end
      endcase
    end
    push_o.cnt = n;
  end

  // Hold the window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      early_q <= '0;
      late_q  <= '0;
      pos_q   <= nms_pkg::POS_START;
    end else begin
      older_q <= older_d;
      newer_q <= newer_d;
      early_q <= early_d;
      late_q  <= late_d;
      pos_q   <= pos_d;
    end
  end

endmodule

@@ rtl/nms_queue.sv @@
// Small result queue taking up to three results per cycle and giving one.
module nms_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nms_pkg::push_t           push_i,
  input  logic                     pop_i,
  output nms_pkg::res_t            head_o,
  output logic [nms_pkg::Q_CW-1:0] count_o
);

  nms_pkg::res_t              mem_q [nms_pkg::Q_DEPTH];
  logic [nms_pkg::Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [nms_pkg::Q_CW-1:0]   count_q;

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Write the new results in order.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < nms_pkg::MAX_PUSH; i++) begin
      if (nms_pkg::PUSH_CW'(i) < push_i.cnt) begin
        mem_q[nms_pkg::Q_AW'(wr_ptr_q + nms_pkg::Q_AW'(i))] <= push_i.res[i];
      end
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= nms_pkg::Q_AW'(wr_ptr_q + nms_pkg::Q_AW'(push_i.cnt));
      rd_ptr_q <= nms_pkg::Q_AW'(rd_ptr_q + nms_pkg::Q_AW'(pop_i));
      count_q  <= nms_pkg::Q_CW'(count_q + nms_pkg::Q_CW'(push_i.cnt)
                                 - nms_pkg::Q_CW'(pop_i));
    end
  end

endmodule

@@ rtl/neighbor_peak_mass_shift.sv @@
// Top level of the neighbor peak mass shift block.
// Input channel: in_valid_i / in_stall_o carry one mass sample per request,
// with frame_end_i marking the last sample of a frame.
// Output channel: out_valid_o / out_stall_i carry one redistributed bin per
// request, in bin order, with out_last_o on the final bin of the frame.
// Each sample's mass moves to a strictly larger neighbor (the larger one
// if both are larger, right on a tie), else stays put.
// Throughput: one sample per cycle while in_stall_o is low. Bin k is written
// to the result queue when sample k+2 is accepted; the last sample releases
// one to three bins at once, which drain one per cycle while the output is
// not stalled, from a four-entry result queue. in_stall_o rises while the
// queue holds two or more bins, so a frame end can stall input as it drains.
// Reset clears the window and empties the queue; a new frame starts.
// A stalled output holds its bin; the queue fills and then stalls input.
module neighbor_peak_mass_shift (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [nms_pkg::MASS_W-1:0] mass_i,
  input  logic                       frame_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [nms_pkg::SUM_W-1:0]  mass_out_o,
  output logic                       out_last_o
);

  nms_pkg::push_t           push;
  nms_pkg::res_t            head;
  logic [nms_pkg::Q_CW-1:0] count;
  logic                     accept, pop;

  // Accept only with room for a full burst of results.
  assign in_stall_o = count > nms_pkg::Q_CW'(nms_pkg::Q_DEPTH - nms_pkg::MAX_PUSH);
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  nms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mass_i      (mass_i),
    .frame_end_i (frame_end_i),
    .push_o      (push)
  );

  nms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  // Drive the output request from the queue head.
  assign out_valid_o = count != '0;
  assign mass_out_o  = head.sum;
  assign out_last_o  = head.last;

endmodule

@@ rtl/nms_checker.sv @@
// Port-level checks of the neighbor peak mass shift block and its binding.
`include "assert_macros.svh"

module nms_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [nms_pkg::MASS_W-1:0] mass_i,
  input logic                       frame_end_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [nms_pkg::SUM_W-1:0]  mass_out_o,
  input logic                       out_last_o
);

  // Hold a stalled output request.
  `NMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(mass_out_o) && $stable(out_last_o))
  // Release at least one bin after any frame end.
  `NMS_ASSERT_NEXT(a_end_emits, clk_i, rst_ni, in_valid_i && !in_stall_o && frame_end_i, out_valid_o)
  // Stall input only while bins wait.
  `NMS_ASSERT_SAME(a_stall_pending, clk_i, rst_ni, in_stall_o, out_valid_o)
  // Keep bins within three full samples.
  `NMS_ASSERT_SAME(a_sum_range, clk_i, rst_ni, out_valid_o, mass_out_o <= nms_pkg::SUM_W'(3 * ((1 << nms_pkg::MASS_W) - 1)))

endmodule

bind neighbor_peak_mass_shift nms_checker u_nms_checker (.*);
